// ----- sv/dominant_gradient_orientation_defines.svh -----
// assertion helpers included by the top-level rtl
`ifndef DOMINANT_GRADIENT_ORIENTATION_DEFINES_SVH
`define DOMINANT_GRADIENT_ORIENTATION_DEFINES_SVH

// same-cycle implication, checked outside reset
`define DGO_ASSERT_IMP(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define DGO_ASSERT_NXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- sv/dgo_pkg.sv -----
`default_nettype none
package dgo_pkg;
	localparam int MAG_MAX = 32767;
	localparam int ONE_Q15 = 32768;
	localparam int DIAG_Q15 = 23170;
	localparam int MAG_BITS = 15;
	localparam int PROJ_BITS = 16;
	localparam int QUOT_BITS = 18;
	localparam int NUM_CHANNELS = 3;
	localparam int NUM_DIRS = 4;

	typedef logic [1:0] chan_t;
	localparam chan_t CH_NONE = 2'd3;

	typedef logic [MAG_BITS-1:0] mag_t;
	typedef logic [PROJ_BITS-1:0] proj_t;

	// sideband that rides through the divider
	typedef struct packed {
		chan_t channel;
		mag_t magnitude;
	} win_t;
endpackage
`default_nettype wire

// ----- sv/dominant_gradient_orientation.sv -----
// channel   | signals                                          | handshake
// ----------+--------------------------------------------------+---------------------------
// request   | red/green/blue_grad_x/y                          | start, busy (always low)
// result    | dominant_channel, dominant_magnitude, proj_*deg  | done, one cycle, no stall
// config    | cfg_wdata                                        | cfg_we
//
// one request enters every cycle and passes capture, radicand, the bit-per-stage root,
// rounding, winner select, dividend, the 18 quotient stages and the output register
// all pipeline valids clear on arst_n; the threshold resets to zero
// nothing stalls: busy is held low and the receiver takes each result on its strobe
`default_nettype none
module dominant_gradient_orientation #(
	parameter int GRADIENT_BITS = 11
) (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic signed [GRADIENT_BITS-1:0] red_grad_x,
	input logic signed [GRADIENT_BITS-1:0] red_grad_y,
	input logic signed [GRADIENT_BITS-1:0] green_grad_x,
	input logic signed [GRADIENT_BITS-1:0] green_grad_y,
	input logic signed [GRADIENT_BITS-1:0] blue_grad_x,
	input logic signed [GRADIENT_BITS-1:0] blue_grad_y,
	input logic cfg_we,
	input logic [dgo_pkg::MAG_BITS-1:0] cfg_wdata,
	output logic done,
	output dgo_pkg::chan_t dominant_channel,
	output dgo_pkg::mag_t dominant_magnitude,
	output dgo_pkg::proj_t proj_0deg,
	output dgo_pkg::proj_t proj_45deg,
	output dgo_pkg::proj_t proj_90deg,
	output dgo_pkg::proj_t proj_135deg
);
	import dgo_pkg::*;
	`include "dominant_gradient_orientation_defines.svh"

	localparam int G = GRADIENT_BITS;
	localparam int AW = G + 1;
	localparam int SQW = 2 * G;
	localparam int RW = 2 * G + 9;
	localparam int MW = (RW + 1) / 2;
	localparam int NW = G + 23;
	localparam int DW = MW + 1;
	localparam int QW = QUOT_BITS;
	localparam int XW = MW + MAG_BITS;
	localparam int TGW = 2 * NUM_CHANNELS * G;
	localparam int LAT = MW + QW + 6;

	function automatic logic [AW-1:0] abs_ext(input logic signed [AW-1:0] v);
		return v[AW-1] ? AW'(-v) : v;
	endfunction

	mag_t threshold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= '0;
		end else if (cfg_we) begin
			threshold_q <= cfg_wdata;
		end
	end

	// the pipeline always advances
	assign busy = 1'b0;

	// stage 1: capture and square
	logic [NUM_CHANNELS-1:0][G-1:0] gx_in, gy_in;
	logic [NUM_CHANNELS-1:0][SQW-1:0] sqx_in, sqy_in;
	logic v_s1;
	logic [NUM_CHANNELS-1:0][G-1:0] gx_s1, gy_s1;
	logic [NUM_CHANNELS-1:0][SQW-1:0] sqx_s1, sqy_s1;

	assign gx_in[0] = red_grad_x;
	assign gy_in[0] = red_grad_y;
	assign gx_in[1] = green_grad_x;
	assign gy_in[1] = green_grad_y;
	assign gx_in[2] = blue_grad_x;
	assign gy_in[2] = blue_grad_y;

	for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_square
		logic [AW-1:0] ax, ay;
		logic [2*AW-1:0] px, py;
		assign ax = abs_ext(AW'($signed(gx_in[c])));
		assign ay = abs_ext(AW'($signed(gy_in[c])));
		assign px = ax * ax;
		assign py = ay * ay;
		assign sqx_in[c] = px[SQW-1:0];
		assign sqy_in[c] = py[SQW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else begin
			v_s1 <= start;
		end
	end

	always_ff @(posedge clk) begin
		gx_s1 <= gx_in;
		gy_s1 <= gy_in;
		sqx_s1 <= sqx_in;
		sqy_s1 <= sqy_in;
	end

	// stage 2: radicand = 256 * (gx^2 + gy^2)
	logic v_s2;
	logic [NUM_CHANNELS-1:0][RW-1:0] rad_s2;
	logic [NUM_CHANNELS-1:0][G-1:0] gx_s2, gy_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			rad_s2[c] <= {(SQW + 1)'(sqx_s1[c]) + (SQW + 1)'(sqy_s1[c]), 8'd0};
		end
		gx_s2 <= gx_s1;
		gy_s2 <= gy_s1;
	end

	logic sq_valid;
	logic [NUM_CHANNELS-1:0][MW-1:0] sq_root;
	logic [NUM_CHANNELS-1:0][RW-1:0] sq_rem;
	logic [TGW-1:0] sq_tag;

	dgo_sqrt #(
		.RW(RW),
		.LN(NUM_CHANNELS),
		.TGW(TGW)
	) u_sqrt (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(v_s2),
		.src_value(rad_s2),
		.src_tag({gx_s2, gy_s2}),
		.res_valid(sq_valid),
		.res_root(sq_root),
		.res_rem(sq_rem),
		.res_tag(sq_tag)
	);

	// stage 3: round to nearest, halves up
	logic v_s3;
	logic [NUM_CHANNELS-1:0][MW-1:0] m_s3;
	logic [NUM_CHANNELS-1:0][G-1:0] gx_s3, gy_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else begin
			v_s3 <= sq_valid;
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			m_s3[c] <= sq_root[c] + MW'(sq_rem[c] > RW'(sq_root[c]));
		end
		{gx_s3, gy_s3} <= sq_tag;
	end

	// stage 4: saturate, pick the winner, form the four absolute components
	mag_t [NUM_CHANNELS-1:0] sat;
	mag_t best;
	chan_t win;
	logic [G-1:0] selx, sely;
	logic [MW-1:0] selm;
	logic [NUM_DIRS-1:0][AW-1:0] comp;

	for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_sat
		logic [XW-1:0] wide;
		assign wide = (XW'(m_s3[c]) > XW'(MAG_MAX)) ? XW'(MAG_MAX) : XW'(m_s3[c]);
		assign sat[c] = wide[MAG_BITS-1:0];
	end

	always_comb begin
		best = threshold_q;
		win = CH_NONE;
		for (int c = 0; c < NUM_CHANNELS; c++) begin
			if (sat[c] > best) begin
				best = sat[c];
				win = chan_t'(c);
			end
		end
	end

	always_comb begin
		case (win)
			2'd0: begin
				selx = gx_s3[0];
				sely = gy_s3[0];
				selm = m_s3[0];
			end
			2'd1: begin
				selx = gx_s3[1];
				sely = gy_s3[1];
				selm = m_s3[1];
			end
			2'd2: begin
				selx = gx_s3[2];
				sely = gy_s3[2];
				selm = m_s3[2];
			end
			default: begin
				selx = '0;
				sely = '0;
				selm = '0;
			end
		endcase
	end

	assign comp[0] = abs_ext(AW'($signed(selx)));
	assign comp[1] = abs_ext(AW'($signed(selx)) + AW'($signed(sely)));
	assign comp[2] = abs_ext(AW'($signed(sely)));
	assign comp[3] = abs_ext(AW'($signed(sely)) - AW'($signed(selx)));

	logic v_s4;
	chan_t chan_s4;
	mag_t mag_s4;
	logic [MW-1:0] m_s4;
	logic [NUM_DIRS-1:0][AW-1:0] comp_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s4 <= 1'b0;
		end else begin
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		chan_s4 <= win;
		mag_s4 <= (win == CH_NONE) ? '0 : best;
		m_s4 <= selm;
		comp_s4 <= comp;
	end

	// stage 5: dividend = 2 * 16 * a * coef + m, divisor = 2 * m
	logic v_s5;
	logic [NUM_DIRS-1:0][NW-1:0] num_s5;
	logic [DW-1:0] den_s5;
	win_t tag_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s5 <= 1'b0;
		end else begin
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		for (int d = 0; d < NUM_DIRS; d++) begin
			if (d == 1 || d == 3) begin
				num_s5[d] <= ((NW'(comp_s4[d]) * NW'(DIAG_Q15)) << 5) + NW'(m_s4);
			end else begin
				num_s5[d] <= ((NW'(comp_s4[d]) * NW'(ONE_Q15)) << 5) + NW'(m_s4);
			end
		end
		den_s5 <= {m_s4, 1'b0};
		tag_s5 <= '{channel: chan_s4, magnitude: mag_s4};
	end

	logic dv_valid;
	logic [NUM_DIRS-1:0][QW-1:0] dv_quot;
	win_t dv_tag;
	logic [$bits(win_t)-1:0] dv_tag_in;

	assign dv_tag_in = tag_s5;

	dgo_div #(
		.NW(NW),
		.DW(DW),
		.QW(QW),
		.LN(NUM_DIRS),
		.TGW($bits(win_t))
	) u_div (
		.clk(clk),
		.arst_n(arst_n),
		.src_valid(v_s5),
		.src_dividend(num_s5),
		.src_divisor(den_s5),
		.src_tag(dv_tag_in),
		.res_valid(dv_valid),
		.res_quot(dv_quot),
		.res_tag(dv_tag)
	);

	// output stage: clamp at 1.0, zero the projections when no channel wins
	proj_t [NUM_DIRS-1:0] pj;

	always_comb begin
		for (int d = 0; d < NUM_DIRS; d++) begin
			if (dv_tag.channel == CH_NONE) begin
				pj[d] = '0;
			end else if (dv_quot[d] > QW'(ONE_Q15)) begin
				pj[d] = PROJ_BITS'(ONE_Q15);
			end else begin
				pj[d] = dv_quot[d][PROJ_BITS-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done <= 1'b0;
		end else begin
			done <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		dominant_channel <= dv_tag.channel;
		dominant_magnitude <= dv_tag.magnitude;
		proj_0deg <= pj[0];
		proj_45deg <= pj[1];
		proj_90deg <= pj[2];
		proj_135deg <= pj[3];
	end

	`DGO_ASSERT_IMP(a_done_has_request, done, $past(start, LAT), "result without a request")
	`DGO_ASSERT_IMP(a_none_is_zero, done && (dominant_channel == CH_NONE),
		(dominant_magnitude == '0) && (proj_0deg == '0) && (proj_45deg == '0)
		&& (proj_90deg == '0) && (proj_135deg == '0), "no winner but non-zero result")
	`DGO_ASSERT_IMP(a_proj_clamped, done, (proj_0deg <= PROJ_BITS'(ONE_Q15))
		&& (proj_90deg <= PROJ_BITS'(ONE_Q15)) && (proj_45deg <= PROJ_BITS'(ONE_Q15))
		&& (proj_135deg <= PROJ_BITS'(ONE_Q15)), "projection above one")
	`DGO_ASSERT_NXT(a_request_enters, start, v_s1, "request not captured")
endmodule
`default_nettype wire

// ----- sv/dgo_sqrt.sv -----
`default_nettype none
module dgo_sqrt #(
	parameter int RW = 31,
	parameter int LN = 3,
	parameter int TGW = 1
) (
	input logic clk,
	input logic arst_n,
	input logic src_valid,
	input logic [LN-1:0][RW-1:0] src_value,
	input logic [TGW-1:0] src_tag,
	output logic res_valid,
	output logic [LN-1:0][(RW+1)/2-1:0] res_root,
	output logic [LN-1:0][RW-1:0] res_rem,
	output logic [TGW-1:0] res_tag
);
	localparam int RB = (RW + 1) / 2;
	localparam int TW = 2 * RB + 1;

	logic valid_s [RB+1];
	logic [LN-1:0][RB-1:0] root_s [RB+1];
	logic [LN-1:0][RW-1:0] rem_s [RB+1];
	logic [TGW-1:0] tag_s [RB+1];

	assign valid_s[0] = src_valid;
	assign root_s[0] = '0;
	assign rem_s[0] = src_value;
	assign tag_s[0] = src_tag;

	// one root bit per stage, most significant first
	for (genvar k = 0; k < RB; k++) begin : g_stage
		localparam int B = RB - 1 - k;
		logic [LN-1:0][RW-1:0] rem_nx;
		logic [LN-1:0][RB-1:0] root_nx;

		for (genvar l = 0; l < LN; l++) begin : g_lane
			logic [TW-1:0] trial;
			logic fits;
			// (r + 2^B)^2 - r^2
			assign trial = (TW'(root_s[k][l]) << (B + 1)) + (TW'(1) << (2 * B));
			assign fits = TW'(rem_s[k][l]) >= trial;
			assign rem_nx[l] = fits ? RW'(TW'(rem_s[k][l]) - trial) : rem_s[k][l];
			assign root_nx[l] = fits ? (root_s[k][l] | (RB'(1) << B)) : root_s[k][l];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			root_s[k+1] <= root_nx;
			rem_s[k+1] <= rem_nx;
			tag_s[k+1] <= tag_s[k];
		end
	end

	assign res_valid = valid_s[RB];
	assign res_root = root_s[RB];
	assign res_rem = rem_s[RB];
	assign res_tag = tag_s[RB];
endmodule
`default_nettype wire

// ----- sv/dgo_div.sv -----
`default_nettype none
module dgo_div #(
	parameter int NW = 34,
	parameter int DW = 17,
	parameter int QW = 18,
	parameter int LN = 4,
	parameter int TGW = 1
) (
	input logic clk,
	input logic arst_n,
	input logic src_valid,
	input logic [LN-1:0][NW-1:0] src_dividend,
	input logic [DW-1:0] src_divisor,
	input logic [TGW-1:0] src_tag,
	output logic res_valid,
	output logic [LN-1:0][QW-1:0] res_quot,
	output logic [TGW-1:0] res_tag
);
	localparam int CW = (NW > DW + QW) ? NW : DW + QW;

	logic valid_s [QW+1];
	logic [LN-1:0][NW-1:0] rem_s [QW+1];
	logic [LN-1:0][QW-1:0] quot_s [QW+1];
	logic [DW-1:0] div_s [QW+1];
	logic [TGW-1:0] tag_s [QW+1];

	assign valid_s[0] = src_valid;
	assign rem_s[0] = src_dividend;
	assign quot_s[0] = '0;
	assign div_s[0] = src_divisor;
	assign tag_s[0] = src_tag;

	// restoring division, one quotient bit per stage, shared divisor across lanes
	for (genvar k = 0; k < QW; k++) begin : g_stage
		localparam int B = QW - 1 - k;
		logic [CW-1:0] shifted;
		logic [LN-1:0][NW-1:0] rem_nx;
		logic [LN-1:0][QW-1:0] quot_nx;

		assign shifted = CW'(div_s[k]) << B;

		for (genvar l = 0; l < LN; l++) begin : g_lane
			logic fits;
			assign fits = CW'(rem_s[k][l]) >= shifted;
			assign rem_nx[l] = fits ? NW'(CW'(rem_s[k][l]) - shifted) : rem_s[k][l];
			assign quot_nx[l] = fits ? (quot_s[k][l] | (QW'(1) << B)) : quot_s[k][l];
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			rem_s[k+1] <= rem_nx;
			quot_s[k+1] <= quot_nx;
			div_s[k+1] <= div_s[k];
			tag_s[k+1] <= tag_s[k];
		end
	end

	assign res_valid = valid_s[QW];
	assign res_quot = quot_s[QW];
	assign res_tag = tag_s[QW];
endmodule
`default_nettype wire

// ----- tb/tb_top.sv -----
`timescale 1ns / 100ps
`default_nettype none
module tb_top;
	import dgo_pkg::*;

	localparam int GB = 11;
	localparam int LATENCY = GB + 29;
	localparam int WATCHDOG_LIMIT = 2000;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic signed [GB-1:0] red_grad_x = '0, red_grad_y = '0;
	logic signed [GB-1:0] green_grad_x = '0, green_grad_y = '0;
	logic signed [GB-1:0] blue_grad_x = '0, blue_grad_y = '0;
	logic cfg_we = 1'b0;
	logic [MAG_BITS-1:0] cfg_wdata = '0;
	logic done;
	chan_t dominant_channel;
	mag_t dominant_magnitude;
	proj_t proj_0deg, proj_45deg, proj_90deg, proj_135deg;

	typedef struct packed {
		chan_t channel;
		mag_t magnitude;
		proj_t p0, p45, p90, p135;
	} orient_t;

	orient_t orient_q[$];
	logic [MAG_BITS-1:0] threshold = '0;
	int errors = 0;
	int idle_cycles = 0;
	int idle_pct = 0;

	dominant_gradient_orientation #(.GRADIENT_BITS(GB)) u_top (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy),
		.red_grad_x(red_grad_x), .red_grad_y(red_grad_y),
		.green_grad_x(green_grad_x), .green_grad_y(green_grad_y),
		.blue_grad_x(blue_grad_x), .blue_grad_y(blue_grad_y),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata), .done(done),
		.dominant_channel(dominant_channel), .dominant_magnitude(dominant_magnitude),
		.proj_0deg(proj_0deg), .proj_45deg(proj_45deg),
		.proj_90deg(proj_90deg), .proj_135deg(proj_135deg)
	);

	always #4 clk = ~clk;

	function automatic longint unsigned root_rounded(longint unsigned n);
		longint unsigned r, lo, hi, mid;
		lo = 0;
		hi = 65536;
		while (lo < hi) begin
			mid = (lo + hi + 1) / 2;
			if (mid * mid <= n) lo = mid;
			else hi = mid - 1;
		end
		r = lo;
		if (n - r * r > r) r = r + 1;
		return r;
	endfunction

	function automatic proj_t unit_proj(longint unsigned a, longint unsigned coef,
			longint unsigned m);
		longint unsigned q;
		q = (2 * a * 16 * coef + m) / (2 * m);
		if (q > ONE_Q15) q = ONE_Q15;
		return q[PROJ_BITS-1:0];
	endfunction

	function automatic longint unsigned mag_abs(longint v);
		return v < 0 ? -v : v;
	endfunction

	function automatic orient_t predict_orientation(logic signed [GB-1:0] g[6]);
		orient_t r;
		longint gx[3], gy[3];
		longint unsigned full[3], sat, best, m;
		int win;
		best = threshold;
		win = -1;
		for (int c = 0; c < 3; c++) begin
			gx[c] = g[2*c];
			gy[c] = g[2*c+1];
			full[c] = root_rounded((gx[c]*gx[c] + gy[c]*gy[c]) * 256);
			sat = full[c] > MAG_MAX ? MAG_MAX : full[c];
			if (sat > best) begin
				best = sat;
				win = c;
			end
		end
		r = '0;
		if (win < 0) begin
			r.channel = CH_NONE;
		end else begin
			m = full[win];
			r.channel = chan_t'(win);
			r.magnitude = best[MAG_BITS-1:0];
			r.p0 = unit_proj(mag_abs(gx[win]), ONE_Q15, m);
			r.p45 = unit_proj(mag_abs(gx[win] + gy[win]), DIAG_Q15, m);
			r.p90 = unit_proj(mag_abs(gy[win]), ONE_Q15, m);
			r.p135 = unit_proj(mag_abs(gy[win] - gx[win]), DIAG_Q15, m);
		end
		return r;
	endfunction

	task automatic send_pixel(logic signed [GB-1:0] g[6]);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		start <= 1'b1;
		red_grad_x <= g[0]; red_grad_y <= g[1];
		green_grad_x <= g[2]; green_grad_y <= g[3];
		blue_grad_x <= g[4]; blue_grad_y <= g[5];
		@(posedge clk);
		while (busy) @(posedge clk);
		orient_q.insert(orient_q.size(), predict_orientation(g));
	endtask

	task automatic drain();
		start <= 1'b0;
		while (orient_q.size() > 0) @(posedge clk);
		repeat (LATENCY + 4) @(posedge clk);
	endtask

	task automatic set_threshold(logic [MAG_BITS-1:0] v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(posedge clk);
		cfg_we <= 1'b0;
		threshold = v;
	endtask

	function automatic logic signed [GB-1:0] rand_grad();
		case ($urandom_range(3))
			0: return GB'($urandom);
			1: return GB'($signed($urandom_range(2040)) - 1020);
			2: return GB'($signed($urandom_range(40)) - 20);
			default: return $urandom_range(1) ? GB'(1020) : GB'(-1020);
		endcase
	endfunction

	task automatic send_all(logic signed [GB-1:0] v);
		logic signed [GB-1:0] g[6];
		foreach (g[i]) g[i] = v;
		send_pixel(g);
	endtask

	task automatic test_directed();
		logic signed [GB-1:0] g[6];
		// zero gradients give no winner
		send_all('0);
		// equal magnitudes, earliest channel keeps the lead
		send_all(GB'(1020));
		send_all(GB'(-1020));
		// full-scale patterns, magnitude stays below MAG_MAX
		send_all(GB'(-1024));
		send_all(GB'(1023));
		g = '{GB'(-1024), GB'(-1024), '0, '0, '0, '0}; send_pixel(g);
		g = '{'0, '0, GB'(3), GB'(4), '0, '0}; send_pixel(g);
		g = '{'0, '0, '0, '0, GB'(-1), GB'(0)}; send_pixel(g);
		g = '{GB'(1), GB'(1), GB'(1), GB'(2), GB'(-3), GB'(1)}; send_pixel(g);
		g = '{GB'(1020), GB'(-1020), GB'(5), GB'(0), GB'(-1020), GB'(1020)}; send_pixel(g);
		g = '{GB'(7), GB'(-7), GB'(0), GB'(9), GB'(1), GB'(-1)}; send_pixel(g);
		g = '{GB'(0), GB'(1), GB'(1), GB'(0), GB'(1), GB'(1)}; send_pixel(g);
		set_threshold(MAG_BITS'(16));
		g = '{GB'(1), GB'(0), GB'(0), GB'(1), GB'(1), GB'(1)}; send_pixel(g);
		set_threshold(MAG_BITS'(23088));
		send_all(GB'(1020));
		send_all(GB'(-1024));
		set_threshold('1);
		send_all(GB'(-1024));
		set_threshold('0);
	endtask

	task automatic test_random(int n, int pct, logic [MAG_BITS-1:0] thr);
		logic signed [GB-1:0] g[6];
		set_threshold(thr);
		idle_pct = pct;
		repeat (n) begin
			foreach (g[i]) g[i] = rand_grad();
			send_pixel(g);
		end
		idle_pct = 0;
	endtask

	// result checker
	always @(posedge clk) begin
		orient_t exp_r;
		if (arst_n && done) begin
			if (orient_q.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				exp_r = orient_q.pop_front();
				if (dominant_channel !== exp_r.channel) begin
					$error("dominant_channel exp %0d got %0d", exp_r.channel, dominant_channel);
					errors++;
				end
				if (dominant_magnitude !== exp_r.magnitude) begin
					$error("dominant_magnitude exp %0d got %0d", exp_r.magnitude,
						dominant_magnitude);
					errors++;
				end
				if (proj_0deg !== exp_r.p0) begin
					$error("proj_0deg exp %0d got %0d", exp_r.p0, proj_0deg);
					errors++;
				end
				if (proj_45deg !== exp_r.p45) begin
					$error("proj_45deg exp %0d got %0d", exp_r.p45, proj_45deg);
					errors++;
				end
				if (proj_90deg !== exp_r.p90) begin
					$error("proj_90deg exp %0d got %0d", exp_r.p90, proj_90deg);
					errors++;
				end
				if (proj_135deg !== exp_r.p135) begin
					$error("proj_135deg exp %0d got %0d", exp_r.p135, proj_135deg);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles without any accepted request, result or config write
	always @(posedge clk) begin
		if ((start && !busy) || done || cfg_we) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("FAIL dominant_gradient_orientation");
			$finish;
		end
	end

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_random(240, 0, MAG_BITS'(0));
		test_random(240, 60, MAG_BITS'($urandom_range(8000)));
		test_random(240, 30, MAG_BITS'($urandom_range(23088)));
		test_random(230, 0, MAG_BITS'(23088));
		drain();
		if (errors == 0 && orient_q.size() == 0) begin
			$display("PASS dominant_gradient_orientation");
		end else begin
			$display("FAIL dominant_gradient_orientation");
		end
		$finish;
	end
endmodule
`default_nettype wire

// ----- dominant_gradient_orientation.f -----
+incdir+sv
sv/dgo_pkg.sv
sv/dgo_sqrt.sv
sv/dgo_div.sv
sv/dominant_gradient_orientation.sv
tb/tb_top.sv
